// ===== rtl/ild_pkg.sv =====
// ild_pkg: shared types and codes for the x86 instruction length decoder
// used by ild_decode, the top level and the port checker; no dependencies

package ild_pkg;

  localparam int unsigned DefMaxLength = 15;

  localparam int unsigned LenW    = 5;
  localparam int unsigned StatusW = 2;

  // decoder phases
  localparam logic [1:0] PH_OPCODE = 2'd0;
  localparam logic [1:0] PH_MODRM  = 2'd1;
  localparam logic [1:0] PH_SIB    = 2'd2;
  localparam logic [1:0] PH_SKIP   = 2'd3;

  // result status codes
  localparam logic [StatusW-1:0] STAT_OK   = 2'd0;
  localparam logic [StatusW-1:0] STAT_ESC  = 2'd1;
  localparam logic [StatusW-1:0] STAT_LONG = 2'd2;

  // group 3 immediate tracking
  localparam logic [1:0] G3_NONE = 2'd0;
  localparam logic [1:0] G3_F6   = 2'd1;
  localparam logic [1:0] G3_F7   = 2'd2;

  typedef struct packed {
    logic [1:0]      phase;
    logic [LenW-1:0] byte_count;
    logic            opsize_flag;
    logic            addrsize_flag;
    logic [2:0]      pending_immediate;
    logic [1:0]      group3_check;
    logic [3:0]      bytes_to_skip;
  } ild_state_t;

  typedef struct packed {
    logic               valid;
    logic [LenW-1:0]    instr_length;
    logic [StatusW-1:0] status;
  } ild_result_t;

endpackage

// ===== rtl/ild_decode.sv =====
// ild_decode: per-byte decode of the length state, one code byte per call
// depends on ild_pkg for the state and result structs and codes

module ild_decode #(
  parameter int unsigned MAX_LENGTH = ild_pkg::DefMaxLength
) (
  input  ild_pkg::ild_state_t  cur,
  input  logic [7:0]           code_byte,
  output ild_pkg::ild_state_t  nxt,
  output ild_pkg::ild_result_t res
);
  import ild_pkg::*;

  typedef struct packed {
    logic       modrm;
    logic [2:0] imm;
    logic [1:0] g3;
  } op_class_t;

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_LENGTH);

  // bytes that steer the opcode phase
  localparam logic [7:0] OP_ESCAPE    = 8'h0f;
  localparam logic [7:0] PFX_OPSIZE   = 8'h66;
  localparam logic [7:0] PFX_ADDRSIZE = 8'h67;

  function automatic logic is_prefix(input logic [7:0] b);
    case (b)
      8'h26, 8'h2e, 8'h36, 8'h3e, 8'h64, 8'h65, 8'h66, 8'h67,
      8'hf0, 8'hf2, 8'hf3: is_prefix = 1'b1;
      default:             is_prefix = 1'b0;
    endcase
  endfunction

  function automatic op_class_t classify(input logic [7:0] op, input logic osz,
                                         input logic asz);
    op_class_t  r;
    logic [2:0] a_b;
    logic [2:0] c;
    logic [2:0] z;
    logic [2:0] far;
    r   = '0;
    a_b = op[5:3];
    c   = op[2:0];
    z   = osz ? 3'd2 : 3'd4;
    far = osz ? 3'd4 : 3'd6;
    case (op[7:6])
      2'd0: begin
        if (c <= 3'd3) r.modrm = 1'b1;
        else if (c == 3'd4) r.imm = 3'd1;
        else if (c == 3'd5) r.imm = z;
      end
      2'd1: begin
        if (a_b == 3'd4 && (c == 3'd2 || c == 3'd3)) begin
          r.modrm = 1'b1;
        end else if (a_b == 3'd5) begin
          case (c)
            3'd0: r.imm = z;
            3'd1: begin r.modrm = 1'b1; r.imm = z; end
            3'd2: r.imm = 3'd1;
            3'd3: begin r.modrm = 1'b1; r.imm = 3'd1; end
            default: ;
          endcase
        end else if (a_b >= 3'd6) begin
          r.imm = 3'd1;
        end
      end
      2'd2: begin
        case (a_b)
          3'd0: begin
            r.modrm = 1'b1;
            if (c == 3'd1) r.imm = z;
            else if (c == 3'd0 || c == 3'd2 || c == 3'd3) r.imm = 3'd1;
          end
          3'd1: r.modrm = 1'b1;
          3'd3: if (c == 3'd2) r.imm = far;
          3'd4: if (c <= 3'd3) r.imm = asz ? 3'd2 : 3'd4;
          3'd5: begin
            if (c == 3'd0) r.imm = 3'd1;
            else if (c == 3'd1) r.imm = z;
          end
          3'd6: r.imm = 3'd1;
          3'd7: r.imm = z;
          default: ;
        endcase
      end
      default: begin
        case (op[5:0])
          6'o00, 6'o01, 6'o06: begin r.modrm = 1'b1; r.imm = 3'd1; end
          6'o02, 6'o12: r.imm = 3'd2;
          6'o04, 6'o05, 6'o20, 6'o21, 6'o22, 6'o23,
          6'o30, 6'o31, 6'o32, 6'o33, 6'o34, 6'o35,
          6'o36, 6'o37, 6'o76, 6'o77: r.modrm = 1'b1;
          6'o07: begin r.modrm = 1'b1; r.imm = z; end
          6'o10: r.imm = 3'd3;
          6'o15, 6'o24, 6'o25, 6'o40, 6'o41, 6'o42,
          6'o43, 6'o44, 6'o45, 6'o46, 6'o47, 6'o53: r.imm = 3'd1;
          6'o50, 6'o51: r.imm = z;
          6'o52: r.imm = far;
          6'o66: begin r.modrm = 1'b1; r.g3 = G3_F6; end
          6'o67: begin r.modrm = 1'b1; r.g3 = G3_F7; end
          default: ;
        endcase
      end
    endcase
    return r;
  endfunction

  logic [LenW-1:0]    cnt;
  logic               done;
  logic [StatusW-1:0] stat;
  logic               aop;
  logic [3:0]         aop_skip;
  logic [2:0]         aop_pend;
  logic [3:0]         total;
  logic [2:0]         disp;
  logic               sib;
  logic [2:0]         pend;
  logic [3:0]         sk;
  op_class_t          cls;

  always_comb begin
    nxt      = cur;
    cnt      = cur.byte_count + LenW'(1);
    nxt.byte_count = cnt;
    done     = 1'b0;
    stat     = STAT_OK;
    aop      = 1'b0;
    aop_skip = '0;
    aop_pend = '0;
    total    = '0;
    disp     = '0;
    sib      = 1'b0;
    pend     = cur.pending_immediate;
    sk       = cur.bytes_to_skip;
    cls      = '0;

    if (cnt > MaxLen) begin
      // check runs ahead of every other decision on this byte
      done = 1'b1;
      stat = STAT_LONG;
    end else begin
      case (cur.phase)
        PH_MODRM: begin
          if (cur.addrsize_flag) begin
            if ((code_byte[7:6] == 2'd0 && code_byte[2:0] == 3'd6) ||
                code_byte[7:6] == 2'd2) disp = 3'd2;
            else if (code_byte[7:6] == 2'd1) disp = 3'd1;
          end else begin
            if ((code_byte[7:6] == 2'd0 && code_byte[2:0] == 3'd5) ||
                code_byte[7:6] == 2'd2) disp = 3'd4;
            else if (code_byte[7:6] == 2'd1) disp = 3'd1;
            sib = (code_byte[7:6] != 2'd3) && (code_byte[2:0] == 3'd4);
          end
          // test-immediate forms of F6/F7 only for reg 0 or 1
          if (code_byte[5:3] <= 3'd1) begin
            if (cur.group3_check == G3_F6) pend = 3'd1;
            else if (cur.group3_check == G3_F7) pend = cur.opsize_flag ? 3'd2 : 3'd4;
          end
          nxt.group3_check  = G3_NONE;
          nxt.bytes_to_skip = {1'b0, disp};
          if (sib) begin
            nxt.phase             = PH_SIB;
            nxt.pending_immediate = pend;
          end else begin
            aop      = 1'b1;
            aop_skip = {1'b0, disp};
            aop_pend = pend;
          end
        end
        PH_SIB: begin
          // zero skip here means mod was 0; base 5 then adds disp32
          if (sk == 4'd0 && code_byte[2:0] == 3'd5) sk = 4'd4;
          aop      = 1'b1;
          aop_skip = sk;
          aop_pend = cur.pending_immediate;
        end
        PH_SKIP: begin
          nxt.bytes_to_skip = cur.bytes_to_skip - 4'd1;
          if (nxt.bytes_to_skip == 4'd0) done = 1'b1;
        end
        default: begin
          if (is_prefix(code_byte)) begin
            if (code_byte == PFX_OPSIZE) nxt.opsize_flag = 1'b1;
            else if (code_byte == PFX_ADDRSIZE) nxt.addrsize_flag = 1'b1;
            nxt.phase = PH_OPCODE;
          end else if (code_byte == OP_ESCAPE) begin
            done = 1'b1;
            stat = STAT_ESC;
          end else begin
            cls = classify(code_byte, cur.opsize_flag, cur.addrsize_flag);
            if (cls.modrm) begin
              nxt.pending_immediate = cls.imm;
              nxt.group3_check      = cls.g3;
              nxt.phase             = PH_MODRM;
            end else begin
              aop      = 1'b1;
              aop_skip = '0;
              aop_pend = cls.imm;
            end
          end
        end
      endcase
    end

    if (aop) begin
      total = aop_skip + {1'b0, aop_pend};
      nxt.pending_immediate = '0;
      if (total == 4'd0) begin
        done = 1'b1;
      end else begin
        nxt.bytes_to_skip = total;
        nxt.phase         = PH_SKIP;
      end
    end

    if (done) nxt = '0;

    res.valid        = done;
    res.instr_length = cnt;
    res.status       = stat;
  end

endmodule

// ===== rtl/x86_instruction_length_decoder_unit.sv =====
// x86_instruction_length_decoder_unit: top level of the length decoder
// depends on ild_pkg and ild_decode
//
// usage:
//   input channel carries one code byte per beat (code_byte, in_valid,
//   in_stall); output channel carries one result per finished instruction
//   (instr_length, status, out_valid, out_stall)
//   a byte beat is taken every cycle while in_stall is low; the single
//   decode pass updates the length state as the byte is taken
//   the result of an instruction is registered when its last byte is taken
//   (or its 0F escape byte, or the byte past MAX_LENGTH) into the result stages
//   status: ok, unsupported 0F escape, or too long (length MAX_LENGTH+1)
//   results sit in an output register backed by a one-entry skid stage, so
//   bytes keep flowing while a result waits; in_stall rises only once the
//   skid stage holds a second waiting result
//   reset (rst, synchronous) clears the decode state to the prefix/opcode
//   phase and drops both result stages

module x86_instruction_length_decoder_unit #(
  parameter int unsigned MAX_LENGTH = ild_pkg::DefMaxLength
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    code_byte,
  input  logic                          in_valid,
  output logic                          in_stall,
  output logic [ild_pkg::LenW-1:0]      instr_length,
  output logic [ild_pkg::StatusW-1:0]   status,
  output logic                          out_valid,
  input  logic                          out_stall
);
  import ild_pkg::*;

  ild_state_t  state;
  ild_state_t  state_next;
  ild_result_t res;

  logic               skid_valid;
  logic [LenW-1:0]    skid_length;
  logic [StatusW-1:0] skid_status;
  logic               take;
  logic               pop;
  logic               new_res;

  ild_decode #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_decode (
    .cur      (state),
    .code_byte(code_byte),
    .nxt      (state_next),
    .res      (res)
  );

  assign in_stall = skid_valid;
  assign take     = in_valid && !skid_valid;
  assign pop      = out_valid && !out_stall;
  assign new_res  = take && res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (new_res) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        instr_length <= skid_length;
        status       <= skid_status;
      end
    end else if (new_res) begin
      if (!out_valid || pop) begin
        instr_length <= res.instr_length;
        status       <= res.status;
      end else begin
        skid_length <= res.instr_length;
        skid_status <= res.status;
      end
    end
  end

endmodule

// ===== rtl/ild_port_check.sv =====
// ild_port_check: port-level assertions for the length decoder top level
// depends on ild_pkg; bound to x86_instruction_length_decoder_unit below

module ild_port_check #(
  parameter int unsigned MAX_LENGTH = ild_pkg::DefMaxLength
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic [ild_pkg::LenW-1:0]    instr_length,
  input logic [ild_pkg::StatusW-1:0] status,
  input logic                        out_valid,
  input logic                        out_stall
);
  import ild_pkg::*;

  localparam logic [LenW-1:0] MaxLen  = LenW'(MAX_LENGTH);
  localparam logic [LenW-1:0] LongLen = LenW'(MAX_LENGTH + 1);

  // a too-long result always reports the byte past the limit
  a_long_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_LONG |-> instr_length == LongLen)
    else $error("too-long result with wrong length");

  // other results hold between one byte and the limit
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_OK || status == STAT_ESC) |->
      instr_length != '0 && instr_length <= MaxLen)
    else $error("result length out of range");

  // only three status codes exist
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STAT_OK || status == STAT_ESC || status == STAT_LONG)
    else $error("bad status code");

  // input stalls only while a result is waiting downstream
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && $past(out_valid))
    else $error("input stalled with no waiting result");

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(instr_length) && $stable(status))
    else $error("stalled result beat changed");

endmodule

bind x86_instruction_length_decoder_unit ild_port_check #(
  .MAX_LENGTH(MAX_LENGTH)
) u_ild_port_check (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .instr_length(instr_length),
  .status      (status),
  .out_valid   (out_valid),
  .out_stall   (out_stall)
);

// ===== sim/tb.sv =====
// tb: self-checking bench for x86_instruction_length_decoder_unit
// drives code bytes, predicts each instruction length and status, checks the results
// depends on ild_pkg and the rtl of the length decoder

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ild_pkg::*;

  localparam int unsigned MaxLen = DefMaxLength;
  localparam int RandomBytes = 1050;
  localparam int QuietTail   = 120;
  localparam int HoldAfter   = 300;
  localparam int LongHold    = 48;
  localparam int IdleLimit   = 2000;
  localparam int DrainCycles = 8;

  // opcodes and prefixes named in the directed rows and the decode
  localparam logic [7:0] OP_NOP       = 8'h90;
  localparam logic [7:0] OP_ESC       = 8'h0F;
  localparam logic [7:0] OP_MOV_MOFFS = 8'hA3;
  localparam logic [7:0] OP_CALL_FAR  = 8'h9A;
  localparam logic [7:0] OP_MOV_R_RM  = 8'h8B;
  localparam logic [7:0] OP_GRP3_B    = 8'hF6;
  localparam logic [7:0] PFX_ES       = 8'h26;
  localparam logic [7:0] PFX_CS       = 8'h2E;
  localparam logic [7:0] PFX_SS       = 8'h36;
  localparam logic [7:0] PFX_DS       = 8'h3E;
  localparam logic [7:0] PFX_FS       = 8'h64;
  localparam logic [7:0] PFX_GS       = 8'h65;
  localparam logic [7:0] PFX_OPSIZE   = 8'h66;
  localparam logic [7:0] PFX_ADDRSIZE = 8'h67;
  localparam logic [7:0] PFX_LOCK     = 8'hF0;
  localparam logic [7:0] PFX_REPNE    = 8'hF2;
  localparam logic [7:0] PFX_REP      = 8'hF3;

  localparam logic [10:0][7:0] PrefixSet = {PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS,
                                            PFX_OPSIZE, PFX_ADDRSIZE, PFX_LOCK, PFX_REPNE,
                                            PFX_REP};
  // modrm and sib bytes that pull in sib, disp8, disp16/32 and base 5
  localparam logic [7:0][7:0] AddrSet = {8'h04, 8'h05, 8'h06, 8'h24, 8'h25, 8'h44, 8'h84,
                                         8'h86};
  // opcodes with the less common operand shapes
  localparam logic [15:0][7:0] OpSet = {8'hF6, 8'hF7, 8'h9A, 8'hEA, 8'hA0, 8'hA1, 8'hA2,
                                        8'hA3, 8'hC8, 8'hC2, 8'h69, 8'h6B, 8'h80, 8'h81,
                                        8'hC7, 8'h8B};

  typedef struct packed {
    logic [LenW-1:0]    len;
    logic [StatusW-1:0] st;
  } length_result_t;

  typedef struct packed {
    logic [7:0]     code;
    logic           typed;
    length_result_t res;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [7:0]          code_byte = 8'h00;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [LenW-1:0]     instr_length;
  logic [StatusW-1:0]  status;
  logic                out_valid;
  logic                out_stall = 1'b0;

  // sideband riding with the offered beat: typed expectation of a directed row
  logic                row_typed = 1'b0;
  length_result_t      row_res = '0;

  length_result_t      expected_lengths[$];
  int                  mismatches = 0;
  int                  n_beats = 0;
  int                  dead_cycles = 0;
  bit                  quiet = 1'b0;
  bit                  calm = 1'b0;

  x86_instruction_length_decoder_unit #(
    .MAX_LENGTH(MaxLen)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .code_byte(code_byte),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .instr_length(instr_length),
    .status(status),
    .out_valid(out_valid),
    .out_stall(out_stall)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- length predictor
  logic [1:0]      dec_phase;
  logic [LenW-1:0] dec_count;
  logic            dec_osz;
  logic            dec_asz;
  logic [2:0]      dec_pend;
  logic [1:0]      dec_g3;
  logic [3:0]      dec_skip;

  task automatic decoder_clear();
    dec_phase = PH_OPCODE;
    dec_count = '0;
    dec_osz   = 1'b0;
    dec_asz   = 1'b0;
    dec_pend  = '0;
    dec_g3    = G3_NONE;
    dec_skip  = '0;
  endtask

  task automatic finish_instr(input logic [StatusW-1:0] st, output bit hit,
                              output length_result_t res);
    res.len = dec_count;
    res.st  = st;
    hit     = 1'b1;
    decoder_clear();
  endtask

  // operand bytes known: either done or skip disp and immediate bytes
  task automatic operands_done(output bit hit, output length_result_t res);
    logic [3:0] total;
    total    = dec_skip + {1'b0, dec_pend};
    dec_pend = '0;
    hit      = 1'b0;
    res      = '0;
    if (total == 4'd0) begin
      finish_instr(STAT_OK, hit, res);
    end else begin
      dec_skip  = total;
      dec_phase = PH_SKIP;
    end
  endtask

  function automatic bit is_prefix(input logic [7:0] v);
    case (v)
      PFX_ES, PFX_CS, PFX_SS, PFX_DS, PFX_FS, PFX_GS, PFX_OPSIZE, PFX_ADDRSIZE,
      PFX_LOCK, PFX_REPNE, PFX_REP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void classify_opcode(input logic [7:0] op, input logic osz,
                                          input logic asz, output bit modrm,
                                          output logic [2:0] imm, output logic [1:0] g3);
    logic [2:0] b;
    logic [2:0] c;
    logic [2:0] z;
    logic [2:0] far;
    b     = op[5:3];
    c     = op[2:0];
    z     = osz ? 3'd2 : 3'd4;
    far   = osz ? 3'd4 : 3'd6;
    modrm = 1'b0;
    imm   = 3'd0;
    g3    = G3_NONE;
    case (op[7:6])
      2'd0: begin
        if (c <= 3'd3) modrm = 1'b1;
        else if (c == 3'd4) imm = 3'd1;
        else if (c == 3'd5) imm = z;
      end
      2'd1: begin
        if (b == 3'd4 && (c == 3'd2 || c == 3'd3)) begin
          modrm = 1'b1;
        end else if (b == 3'd5) begin
          case (c)
            3'd0: imm = z;
            3'd1: begin modrm = 1'b1; imm = z; end
            3'd2: imm = 3'd1;
            3'd3: begin modrm = 1'b1; imm = 3'd1; end
            default: ;
          endcase
        end else if (b >= 3'd6) begin
          imm = 3'd1;
        end
      end
      2'd2: begin
        case (b)
          3'd0: begin
            modrm = 1'b1;
            imm = (c == 3'd1) ? z : (c <= 3'd3) ? 3'd1 : 3'd0;
          end
          3'd1: modrm = 1'b1;
          3'd3: if (c == 3'd2) imm = far;
          3'd4: if (c <= 3'd3) imm = asz ? 3'd2 : 3'd4;
          3'd5: begin
            if (c == 3'd0) imm = 3'd1;
            else if (c == 3'd1) imm = z;
          end
          3'd6: imm = 3'd1;
          3'd7: imm = z;
          default: ;
        endcase
      end
      default: begin
        case (op[5:0])
          6'o00, 6'o01, 6'o06: begin modrm = 1'b1; imm = 3'd1; end
          6'o02, 6'o12: imm = 3'd2;
          6'o04, 6'o05, 6'o20, 6'o21, 6'o22, 6'o23, 6'o30, 6'o31, 6'o32, 6'o33,
          6'o34, 6'o35, 6'o36, 6'o37, 6'o76, 6'o77: modrm = 1'b1;
          6'o07: begin modrm = 1'b1; imm = z; end
          6'o10: imm = 3'd3;
          6'o15, 6'o24, 6'o25, 6'o40, 6'o41, 6'o42, 6'o43, 6'o44, 6'o45, 6'o46,
          6'o47, 6'o53: imm = 3'd1;
          6'o50, 6'o51: imm = z;
          6'o52: imm = far;
          6'o66: begin modrm = 1'b1; g3 = G3_F6; end
          6'o67: begin modrm = 1'b1; g3 = G3_F7; end
          default: ;
        endcase
      end
    endcase
  endfunction

  task automatic predict_length(input logic [7:0] v, output bit hit,
                                output length_result_t res);
    logic [1:0] md;
    logic [2:0] rm;
    logic [3:0] disp;
    bit         sib;
    bit         modrm;
    logic [2:0] imm;
    logic [1:0] g3;
    hit = 1'b0;
    res = '0;
    dec_count = dec_count + LenW'(1);
    // length limit wins over every other decision on this byte
    if (dec_count > MaxLen) begin
      finish_instr(STAT_LONG, hit, res);
    end else begin
      case (dec_phase)
        PH_MODRM: begin
          md   = v[7:6];
          rm   = v[2:0];
          disp = 4'd0;
          sib  = 1'b0;
          if (dec_asz) begin
            if ((md == 2'd0 && rm == 3'd6) || md == 2'd2) disp = 4'd2;
            else if (md == 2'd1) disp = 4'd1;
          end else begin
            if ((md == 2'd0 && rm == 3'd5) || md == 2'd2) disp = 4'd4;
            else if (md == 2'd1) disp = 4'd1;
            sib = (md != 2'd3 && rm == 3'd4);
          end
          // test-immediate forms of group 3 only for reg 0 and 1
          if (v[5:3] <= 3'd1) begin
            if (dec_g3 == G3_F6) dec_pend = 3'd1;
            else if (dec_g3 == G3_F7) dec_pend = dec_osz ? 3'd2 : 3'd4;
          end
          dec_g3   = G3_NONE;
          dec_skip = disp;
          if (sib) dec_phase = PH_SIB;
          else operands_done(hit, res);
        end
        PH_SIB: begin
          if (dec_skip == 4'd0 && v[2:0] == 3'd5) dec_skip = 4'd4;
          operands_done(hit, res);
        end
        PH_SKIP: begin
          dec_skip = dec_skip - 4'd1;
          if (dec_skip == 4'd0) finish_instr(STAT_OK, hit, res);
        end
        default: begin
          if (is_prefix(v)) begin
            if (v == PFX_OPSIZE) dec_osz = 1'b1;
            else if (v == PFX_ADDRSIZE) dec_asz = 1'b1;
            dec_phase = PH_OPCODE;
          end else if (v == OP_ESC) begin
            finish_instr(STAT_ESC, hit, res);
          end else begin
            classify_opcode(v, dec_osz, dec_asz, modrm, imm, g3);
            if (modrm) begin
              dec_pend  = imm;
              dec_g3    = g3;
              dec_phase = PH_MODRM;
            end else begin
              dec_skip = 4'd0;
              dec_pend = imm;
              operands_done(hit, res);
            end
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin : monitor
    bit             hit;
    length_result_t pred;
    length_result_t want;
    if (rst) begin
      decoder_clear();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_lengths.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual len %0d status %0d",
                   $time, instr_length, status);
          mismatches++;
        end else begin
          want = expected_lengths.pop_front();
          if (instr_length !== want.len) begin
            $display("%0t: instr_length mismatch: expected %0d, actual %0d",
                     $time, want.len, instr_length);
            mismatches++;
          end
          if (status !== want.st) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.st, status);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        n_beats++;
        predict_length(code_byte, hit, pred);
        if (row_typed) expected_lengths.push_back(row_res);
        else if (hit) expected_lengths.push_back(pred);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= IdleLimit) begin
      $display("%0t: watchdog: no beat for %0d cycles", $time, IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin : sink
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!held && n_beats >= HoldAfter) begin
        // long hold-off: skid fills and the decoder stalls its input
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic offer_byte(input logic [7:0] v, input logic typed, input length_result_t res);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    code_byte <= v;
    row_typed <= typed;
    row_res   <= res;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic stim_row_t stim_row(input logic [7:0] v, input logic typed,
                                         input int len, input logic [StatusW-1:0] st);
    stim_row_t r;
    r.code    = v;
    r.typed   = typed;
    r.res.len = len[LenW-1:0];
    r.res.st  = st;
    return r;
  endfunction

  initial begin : stim
    stim_row_t  dir_tab[$];
    int         n;
    int         r;
    int         run;
    logic [7:0] v;

    // one-byte opcode and bare escape
    dir_tab.push_back(stim_row(OP_NOP, 1'b1, 1, STAT_OK));
    dir_tab.push_back(stim_row(OP_ESC, 1'b1, 1, STAT_ESC));
    // memory offset with address override: 2 offset bytes
    dir_tab.push_back(stim_row(PFX_ADDRSIZE, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(OP_MOV_MOFFS, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'h00, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'hFF, 1'b1, 4, STAT_OK));
    // far pointer with operand override: 4 immediate bytes
    dir_tab.push_back(stim_row(PFX_OPSIZE, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(OP_CALL_FAR, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'h11, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'h22, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'h33, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'h44, 1'b1, 6, STAT_OK));
    // sib with base 5 under mod 0: disp32 follows
    dir_tab.push_back(stim_row(OP_MOV_R_RM, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'h04, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'h25, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'h00, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'hFF, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'h00, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'hFF, 1'b1, 7, STAT_OK));
    // test-immediate form of F6
    dir_tab.push_back(stim_row(OP_GRP3_B, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'hC0, 1'b0, 0, STAT_OK));
    dir_tab.push_back(stim_row(8'hFF, 1'b1, 3, STAT_OK));
    // too long: the escape after 15 prefixes still loses to the limit
    for (int i = 0; i < MaxLen; i++) begin
      dir_tab.push_back(stim_row(PrefixSet[i % 11], 1'b0, 0, STAT_OK));
    end
    dir_tab.push_back(stim_row(OP_ESC, 1'b1, MaxLen + 1, STAT_LONG));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) offer_byte(dir_tab[i].code, dir_tab[i].typed, dir_tab[i].res);

    n = 0;
    while (n < RandomBytes) begin
      quiet = (n >= RandomBytes - QuietTail);
      calm  = ((n / 90) % 4) == 2;
      r = $urandom_range(0, 99);
      if (r >= 98) begin
        // prefix run long enough to hit the length limit now and then
        run = $urandom_range(12, 16);
        repeat (run) begin
          offer_byte(PrefixSet[$urandom_range(0, 10)], 1'b0, '0);
          n++;
        end
      end else begin
        if (r < 55) v = $urandom_range(0, 255);
        else if (r < 70) v = PrefixSet[$urandom_range(0, 10)];
        else if (r < 73) v = OP_ESC;
        else if (r < 86) v = AddrSet[$urandom_range(0, 7)];
        else v = OpSet[$urandom_range(0, 15)];
        offer_byte(v, 1'b0, '0);
        n++;
      end
    end
    in_valid <= 1'b0;

    while (expected_lengths.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
